[hw/rtl/gbks_pkg.sv]
// ----------------------------------------------------------------------------
// gbks_pkg
// Shared widths, codes and transaction types of the group-by-key sorter.
// ----------------------------------------------------------------------------
package gbks_pkg;

	localparam int GROUP_W         = 12;
	localparam int MEMBER_W        = 18;
	localparam int KEY_W           = GROUP_W + MEMBER_W;
	localparam int COUNT_W         = 11;
	localparam int STORE_DEPTH_DEF = 1024;
	localparam int GROUPS_DEF      = 4096;
	localparam logic [GROUP_W-1:0] LIMIT_RESET = '1;

	typedef enum logic [1:0] {
		FUNC_ENROLL = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_QUERY  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [GROUP_W-1:0]  group_id;
		logic [MEMBER_W-1:0] member_code;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [GROUP_W-1:0]  out_group;
		logic [MEMBER_W-1:0] out_member;
		logic [COUNT_W-1:0]  group_count;
		logic                first_of_group;
	} rsp_t;

	// Broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic             ins;
		logic             pop;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

[hw/rtl/gbks_if.sv]
// ----------------------------------------------------------------------------
// gbks_if
// Valid/ready channels for requests and responses of the sorter.
// ----------------------------------------------------------------------------
interface gbks_req_if;
	logic           valid;
	logic           ready;
	gbks_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface gbks_rsp_if;
	logic           valid;
	logic           ready;
	gbks_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/gbks_ram.sv]
// ----------------------------------------------------------------------------
// gbks_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/gbks_cell.sv]
// ----------------------------------------------------------------------------
// gbks_cell
// One slot of the sorted chain: compare against the broadcast key, then
// take the new key, take the left neighbor, take the right neighbor or hold.
// ----------------------------------------------------------------------------
module gbks_cell (
	input  logic                        clk,
	input  gbks_pkg::cell_ctrl_t        ctrl,
	input  logic                        occ,
	input  logic                        left_big,
	input  logic [gbks_pkg::KEY_W-1:0]  left_key,
	input  logic [gbks_pkg::KEY_W-1:0]  right_key,
	output logic [gbks_pkg::KEY_W-1:0]  cell_key,
	output logic                        big
);
	import gbks_pkg::*;

	logic [KEY_W-1:0] key_q;

	// Empty slots count as larger than any key; equal keys stay ahead.
	assign big      = !occ || (key_q > ctrl.key);
	assign cell_key = key_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_big) begin
				key_q <= left_key;
			end else if (big) begin
				key_q <= ctrl.key;
			end
		end else if (ctrl.pop) begin
			key_q <= right_key;
		end
	end

endmodule

[hw/rtl/group_by_key_sorter.sv]
// ----------------------------------------------------------------------------
// group_by_key_sorter
// Sorted store of (group, member) pairs with per-group enrollment counts.
// ----------------------------------------------------------------------------
// The accept cycle of a request issues the read of the per-group count
// memory, and the execute state then works against its registered read
// data, updating the chain of sort cells, the fill count and the count
// memory together. That execute cycle waits only while an earlier response
// is still held in the output register. After reset the block clears the
// count memory, one entry per cycle, and takes no request during that
// pass; group_limit writes are taken at any time.
// ----------------------------------------------------------------------------
module group_by_key_sorter #(
	parameter int STORE_DEPTH = gbks_pkg::STORE_DEPTH_DEF,
	parameter int GROUPS      = gbks_pkg::GROUPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gbks_req_if.sink                      req,
	gbks_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [gbks_pkg::GROUP_W-1:0]  cfg_wdata
);
	import gbks_pkg::*;

	localparam int FW = $clog2(STORE_DEPTH + 1);
	localparam int AW = $clog2(GROUPS);

	state_t              state_q, state_d;
	logic [GROUP_W-1:0]  limit_q;
	logic [FW-1:0]       fill_q;
	logic [AW-1:0]       clr_q;
	logic                last_valid_q;
	logic [GROUP_W-1:0]  last_grp_q;
	logic                out_valid_q;
	rsp_t                out_q;
	logic [1:0]          func_q;
	logic [GROUP_W-1:0]  group_q;
	logic [MEMBER_W-1:0] member_q;

	logic                exec_go;
	logic                accept;
	logic                clearing;
	logic                grp_ok;
	logic                full;
	logic                do_ins;
	logic                do_pop;
	logic                first;
	rsp_t                res;
	logic [COUNT_W-1:0]  cnt_rd;
	logic [AW-1:0]       ram_raddr;
	logic [AW-1:0]       ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic                ram_we;
	logic [GROUP_W-1:0]  head_grp;
	logic [MEMBER_W-1:0] head_mem;
	cell_ctrl_t          ctrl;

	logic [KEY_W-1:0] cell_key  [STORE_DEPTH];
	logic             cell_big  [STORE_DEPTH];
	logic [KEY_W-1:0] left_key  [STORE_DEPTH];
	logic [KEY_W-1:0] right_key [STORE_DEPTH];
	logic             left_big  [STORE_DEPTH];

	// ---------------- control FSM ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		clearing  = 1'b0;
		exec_go   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == AW'(GROUPS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				exec_go = !out_valid_q || rsp.ready;
				if (exec_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= LIMIT_RESET;
			fill_q       <= '0;
			clr_q        <= '0;
			last_valid_q <= 1'b0;
			last_grp_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (clearing) begin
				clr_q <= clr_q + AW'(1);
			end
			if (do_ins) begin
				fill_q <= fill_q + FW'(1);
			end else if (do_pop) begin
				fill_q <= fill_q - FW'(1);
			end
			if (do_pop) begin
				last_valid_q <= 1'b1;
				last_grp_q   <= head_grp;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request fields for the execute cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.payload.func;
			group_q  <= req.payload.group_id;
			member_q <= req.payload.member_code;
		end
		if (exec_go) begin
			out_q <= res;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// ---------------- count memory ----------------
	assign ram_raddr = (req.payload.func == FUNC_POP) ? AW'(head_grp)
	                                                  : AW'(req.payload.group_id);
	assign ram_we    = clearing || do_ins;
	assign ram_waddr = clearing ? clr_q : AW'(group_q);
	assign ram_wdata = clearing ? '0 : cnt_rd + COUNT_W'(1);

	gbks_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (GROUPS)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (cnt_rd)
	);

	// ---------------- execute ----------------
	assign head_grp = cell_key[0][KEY_W-1 -: GROUP_W];
	assign head_mem = cell_key[0][MEMBER_W-1:0];
	assign grp_ok   = (group_q != '0) && (group_q <= limit_q)
	                  && ({20'd0, group_q} < 32'(GROUPS));
	assign full     = (fill_q == FW'(STORE_DEPTH));
	assign first    = !last_valid_q || (last_grp_q != head_grp);

	always_comb begin
		res    = '0;
		do_ins = 1'b0;
		do_pop = 1'b0;
		case (func_q)
			FUNC_ENROLL: begin
				res.out_group  = group_q;
				res.out_member = member_q;
				if (!grp_ok) begin
					res.status = STAT_RANGE;
				end else if (full) begin
					res.status      = STAT_FULL;
					res.group_count = cnt_rd;
				end else begin
					res.status      = STAT_OK;
					res.group_count = cnt_rd + COUNT_W'(1);
					do_ins          = exec_go;
				end
			end
			FUNC_POP: begin
				if (fill_q == '0) begin
					res.status = STAT_EMPTY;
				end else begin
					res.status         = STAT_OK;
					res.out_group      = head_grp;
					res.out_member     = head_mem;
					res.group_count    = cnt_rd;
					res.first_of_group = first;
					do_pop             = exec_go;
				end
			end
			FUNC_QUERY: begin
				res.out_group = group_q;
				if (grp_ok) begin
					res.status      = STAT_OK;
					res.group_count = cnt_rd;
				end else begin
					res.status = STAT_RANGE;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// ---------------- sorted chain ----------------
	assign ctrl.ins = do_ins;
	assign ctrl.pop = do_pop;
	assign ctrl.key = {group_q, member_q};

	for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign left_big[g] = 1'b0;
			assign left_key[g] = '0;
		end else begin : g_body
			assign left_big[g] = cell_big[g-1];
			assign left_key[g] = cell_key[g-1];
		end
		if (g == STORE_DEPTH - 1) begin : g_tail
			assign right_key[g] = cell_key[g];
		end else begin : g_mid
			assign right_key[g] = cell_key[g+1];
		end

		gbks_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (FW'(g) < fill_q),
			.left_big  (left_big[g]),
			.left_key  (left_key[g]),
			.right_key (right_key[g]),
			.cell_key  (cell_key[g]),
			.big       (cell_big[g])
		);
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STORE_DEPTH))
		else $error("fill count beyond store depth");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q >= FW'(2)) |-> (cell_key[0] <= cell_key[1]))
		else $error("chain head out of order");

	a_exec_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> rsp.valid)
		else $error("executed transaction left no response");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("request taken during count clear");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for group_by_key_sorter. A scoreboard keeps its own
// sorted pair list and per-group enrollment counts, predicts one response per
// accepted request and checks responses in order, under several
// group_limit settings and several patterns of request gaps and response
// stalls, including a long response hold-off while requests keep coming.
// ----------------------------------------------------------------------------
module tb;
	import gbks_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [GROUP_W-1:0] cfg_wdata;

	gbks_req_if req_ch ();
	gbks_rsp_if rsp_ch ();

	group_by_key_sorter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// scoreboard state
	logic [KEY_W-1:0] pair_list[$];
	int unsigned enrolled[GROUPS_DEF];
	logic [GROUP_W-1:0] last_pop_group;
	bit popped_any;
	logic [GROUP_W-1:0] limit_cfg;

	req_t req_backlog[$];
	rsp_t due_rsp[$];

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_armed;
	bit hold_used;
	int hold_left;

	int fail_count;
	int n_req, n_rsp, n_full, n_empty, n_range, n_first;

	function automatic bit group_in_range(logic [GROUP_W-1:0] g);
		return g >= 1 && g <= limit_cfg && int'(g) < GROUPS_DEF;
	endfunction

	// Apply one request to the scoreboard state and return its response.
	function automatic rsp_t step_sorter(req_t r);
		rsp_t o;
		logic [KEY_W-1:0] key;
		logic [GROUP_W-1:0] g;
		int pos;
		o = '0;
		g = r.group_id;
		case (r.func)
			FUNC_ENROLL: begin
				o.out_group = g;
				o.out_member = r.member_code;
				if (!group_in_range(g)) begin
					o.status = STAT_RANGE;
				end else if (pair_list.size() >= STORE_DEPTH_DEF) begin
					o.status = STAT_FULL;
					o.group_count = COUNT_W'(enrolled[g]);
				end else begin
					key = {g, r.member_code};
					pos = pair_list.size();
					while (pos > 0 && pair_list[pos-1] > key)
						pos--;
					pair_list.insert(pos, key);
					enrolled[g]++;
					o.status = STAT_OK;
					o.group_count = COUNT_W'(enrolled[g]);
				end
			end
			FUNC_POP: begin
				if (pair_list.size() == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					key = pair_list.pop_front();
					o.status = STAT_OK;
					o.out_group = key[KEY_W-1:MEMBER_W];
					o.out_member = key[MEMBER_W-1:0];
					o.group_count = COUNT_W'(enrolled[o.out_group]);
					o.first_of_group = !popped_any || last_pop_group != o.out_group;
					last_pop_group = o.out_group;
					popped_any = 1'b1;
				end
			end
			FUNC_QUERY: begin
				o.out_group = g;
				if (!group_in_range(g))
					o.status = STAT_RANGE;
				else
					o.group_count = COUNT_W'(enrolled[g]);
			end
			default: ;
		endcase
		return o;
	endfunction

	// append one request to the pending list
	task automatic add_req(req_t r);
		req_backlog.insert(req_backlog.size(), r);
	endtask

	task automatic check_field(string name, int unsigned exp, int unsigned got);
		if (exp != got) begin
			$error("%s: expected %0d, got %0d", name, exp, got);
			fail_count++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.payload <= req_backlog.pop_front();
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response receiver, with one long hold-off when armed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_used <= 1'b0;
			hold_left <= 0;
		end else if (hold_armed && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on request transaction, check on response transaction
	always @(posedge clk) begin
		rsp_t exp_rsp;
		rsp_t got_rsp;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				exp_rsp = step_sorter(req_ch.payload);
				due_rsp.insert(due_rsp.size(), exp_rsp);
				n_req++;
				case (exp_rsp.status)
					STAT_FULL: n_full++;
					STAT_EMPTY: n_empty++;
					STAT_RANGE: n_range++;
					default: ;
				endcase
				if (exp_rsp.first_of_group)
					n_first++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp = rsp_ch.payload;
				n_rsp++;
				if (due_rsp.size() == 0) begin
					$error("unexpected response transaction %h", got_rsp);
					fail_count++;
				end else begin
					exp_rsp = due_rsp.pop_front();
					check_field("status", exp_rsp.status, got_rsp.status);
					check_field("out_group", exp_rsp.out_group, got_rsp.out_group);
					check_field("out_member", exp_rsp.out_member, got_rsp.out_member);
					check_field("group_count", exp_rsp.group_count, got_rsp.group_count);
					check_field("first_of_group", exp_rsp.first_of_group,
						got_rsp.first_of_group);
				end
			end
		end
	end

	function automatic req_t make_req(logic [1:0] f, logic [GROUP_W-1:0] g,
			logic [MEMBER_W-1:0] m);
		req_t r;
		r.func = f;
		r.group_id = g;
		r.member_code = m;
		return r;
	endfunction

	function automatic logic [GROUP_W-1:0] pick_group();
		int r;
		int top;
		r = $urandom_range(9);
		top = (limit_cfg < 6) ? int'(limit_cfg) : 6;
		if (r == 0)
			return '0;
		if (r <= 2 || top == 0)
			return GROUP_W'($urandom_range(4095));
		if (r == 3)
			return limit_cfg;
		if (r == 4)
			return limit_cfg + 1'b1;
		return GROUP_W'($urandom_range(top, 1));
	endfunction

	function automatic logic [MEMBER_W-1:0] pick_member();
		if ($urandom_range(1))
			return MEMBER_W'($urandom_range(7));
		return MEMBER_W'($urandom_range((1 << MEMBER_W) - 1));
	endfunction

	task automatic queue_random(int n, int pop_pct);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < pop_pct)
				add_req(make_req(FUNC_POP, GROUP_W'($urandom), MEMBER_W'($urandom)));
			else if (r < pop_pct + 15)
				add_req(make_req(FUNC_QUERY, pick_group(), MEMBER_W'($urandom)));
			else if (r < pop_pct + 19)
				add_req(make_req(FUNC_SPARE, GROUP_W'($urandom), MEMBER_W'($urandom)));
			else
				add_req(make_req(FUNC_ENROLL, pick_group(), pick_member()));
		end
	endtask

	// hold until every queued request has been answered
	task automatic wait_idle();
		while (req_backlog.size() > 0 || req_ch.valid || due_rsp.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [GROUP_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_cfg = v;
		@(posedge clk);
	endtask

	task automatic set_pace(int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_armed = 1'b0;
		popped_any = 1'b0;
		last_pop_group = '0;
		limit_cfg = LIMIT_RESET;
		fail_count = 0;
		foreach (enrolled[i])
			enrolled[i] = 0;
		set_pace(0, 0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, range edges, extreme keys, duplicates, spare func
		add_req(make_req(FUNC_POP, '0, '0));
		add_req(make_req(FUNC_QUERY, '0, '1));
		add_req(make_req(FUNC_ENROLL, '0, 18'd5));
		add_req(make_req(FUNC_ENROLL, 12'd4095, '1));
		add_req(make_req(FUNC_ENROLL, 12'd1, '0));
		add_req(make_req(FUNC_ENROLL, 12'd1, '0));
		add_req(make_req(FUNC_ENROLL, 12'd4095, '0));
		add_req(make_req(FUNC_ENROLL, 12'd2, 18'd175759));
		add_req(make_req(FUNC_ENROLL, 12'hAAA, 18'h2AAAA));
		add_req(make_req(FUNC_ENROLL, 12'h555, 18'h15555));
		add_req(make_req(FUNC_QUERY, 12'd1, '0));
		add_req(make_req(FUNC_QUERY, 12'd4095, '0));
		add_req(make_req(FUNC_QUERY, 12'd7, '0));
		add_req(make_req(FUNC_SPARE, 12'hFFF, '1));
		repeat (8)
			add_req(make_req(FUNC_POP, '1, '1));
		add_req(make_req(FUNC_POP, '0, '0));
		wait_idle();

		// every enroll and query out of range with the lowest limit
		write_limit('0);
		set_pace(79, 0);
		queue_random(30, 25);
		wait_idle();

		write_limit(GROUP_W'($urandom_range(4094, 2)));
		set_pace(0, 79);
		queue_random(150, 30);
		wait_idle();

		write_limit('1);
		set_pace(9, 9);
		queue_random(150, 35);
		wait_idle();

		// keep offering enrolls while the receiver holds off
		set_pace(0, 0);
		hold_armed = 1'b1;
		repeat (250)
			add_req(make_req(FUNC_ENROLL,
				$urandom_range(7) == 0 ? GROUP_W'($urandom_range(4095, 1)) : 12'd3,
				pick_member()));
		add_req(make_req(FUNC_QUERY, 12'd3, '0));
		wait_idle();

		write_limit(12'd20);
		set_pace(79, 0);
		queue_random(120, 60);
		wait_idle();

		write_limit(12'd1);
		set_pace(9, 79);
		queue_random(80, 45);
		wait_idle();

		repeat (20) @(posedge clk);
		$display("%0d requests and %0d responses checked over 7 phases",
			n_req, n_rsp);
		$display("%0d store full, %0d store empty, %0d out of range, %0d group starts",
			n_full, n_empty, n_range, n_first);
		if (fail_count == 0) begin
			$display("[group_by_key_sorter] OK");
		end else begin
			$display("[group_by_key_sorter] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[group_by_key_sorter] ERROR");
		$finish;
	end

endmodule

[group_by_key_sorter.f]
hw/rtl/gbks_pkg.sv
hw/rtl/gbks_if.sv
hw/rtl/gbks_ram.sv
hw/rtl/gbks_cell.sv
hw/rtl/group_by_key_sorter.sv
tb/tb.sv
